// ===== rtl/htab_pkg.sv =====
// Shared constants, codes and types of the handle table allocator.
`default_nettype none

package htab_pkg;

	localparam int CAPACITY   = 1024;
	localparam int VALUE_BITS = 64;

	localparam int KEY_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int REG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int FUNC_W    = 2;
	localparam int STAT_W    = 2;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL        = 2'd1;
	localparam logic [STAT_W-1:0] STAT_KEY_INVALID = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_CFG     = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_KEYS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GROW_BY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT = 2'd2;

	// register reset values
	localparam logic [REG_W-1:0] START_KEYS_RST = 11'd16;
	localparam logic [REG_W-1:0] GROW_BY_RST    = 11'd16;
	localparam logic [REG_W-1:0] SIZE_LIMIT_RST = 11'd1024;

	// configuration seen by the controller
	typedef struct packed {
		logic             reinit;
		logic [CNT_W-1:0] reload_size;
		logic [CNT_W-1:0] grow_by;
		logic [CNT_W-1:0] eff_max;
		logic             bad;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/htab_req_if.sv =====
// Request channel: operation, key and value with valid/ready.
`default_nettype none

interface htab_req_if
	import htab_pkg::*;
	();
	logic                  valid;
	logic                  ready;
	logic [FUNC_W-1:0]     func;
	logic [KEY_W-1:0]      key;
	logic [VALUE_BITS-1:0] value;

	modport source(output valid, output func, output key, output value, input ready);
	modport sink(input valid, input func, input key, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/htab_rsp_if.sv =====
// Response channel: key, value and status with valid/ready.
`default_nettype none

interface htab_rsp_if
	import htab_pkg::*;
	();
	logic                  valid;
	logic                  ready;
	logic [KEY_W-1:0]      out_key;
	logic [VALUE_BITS-1:0] out_value;
	logic [STAT_W-1:0]     status;

	modport source(output valid, output out_key, output out_value, output status,
		input ready);
	modport sink(input valid, input out_key, input out_value, input status,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/htab_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module htab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/htab_ctrl.sv =====
// Allocation controller: free-list pointers, entry and recycle memories, result register.
`default_nettype none

module htab_ctrl
	import htab_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	htab_req_if.sink   req,
	htab_rsp_if.source rsp
);

	localparam int ENT_W = VALUE_BITS + 1;

	localparam logic [2:0] OP_INS_FRESH = 3'd0;
	localparam logic [2:0] OP_INS_FIFO  = 3'd1;
	localparam logic [2:0] OP_GET       = 3'd2;
	localparam logic [2:0] OP_REM       = 3'd3;
	localparam logic [2:0] OP_FAIL      = 3'd4;

	function automatic logic [KEY_W-1:0] ring_next(input logic [KEY_W-1:0] p);
		return (p == KEY_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
	endfunction

	// control state
	logic [CNT_W-1:0] fresh_next_q;
	logic [CNT_W-1:0] active_size_q;
	logic [KEY_W-1:0] fifo_head_q;
	logic [KEY_W-1:0] fifo_tail_q;
	logic [CNT_W-1:0] fifo_count_q;
	logic             s1_valid_q;
	logic             rsp_valid_q;

	// stage 1 payload
	logic [2:0]            op_s1;
	logic [KEY_W-1:0]      key_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic                  key_ok_s1;
	logic [STAT_W-1:0]     fail_stat_s1;

	// result register
	logic [KEY_W-1:0]      rsp_key_q;
	logic [VALUE_BITS-1:0] rsp_value_q;
	logic [STAT_W-1:0]     rsp_status_q;

	// memory ports
	logic [ENT_W-1:0] ent_rdata;
	logic [ENT_W-1:0] ent_wdata;
	logic             ent_we;
	logic             ent_re;
	logic [KEY_W-1:0] fifo_rdata;
	logic             fifo_re;

	logic             accept;
	logic             done;
	logic [CNT_W:0]   grown;
	logic             can_grow;
	logic [CNT_W-1:0] size_eff;
	logic [2:0]       op_d;
	logic [STAT_W-1:0] stat_d;
	logic             hit;
	logic [KEY_W-1:0] slot;
	logic             rem_push;
	logic [KEY_W-1:0]      res_key;
	logic [VALUE_BITS-1:0] res_value;
	logic [STAT_W-1:0]     res_stat;

	assign req.ready = !s1_valid_q;
	assign accept    = req.valid && req.ready;
	assign done      = s1_valid_q && (!rsp_valid_q || rsp.ready);

	// growth decision for an insert
	assign grown    = {1'b0, active_size_q} + {1'b0, cfg.grow_by};
	assign can_grow = (fresh_next_q >= active_size_q) && (fifo_count_q == '0) &&
		(grown <= {1'b0, cfg.eff_max});
	assign size_eff = can_grow ? grown[CNT_W-1:0] : active_size_q;

	always_comb begin
		op_d   = OP_FAIL;
		stat_d = STAT_KEY_INVALID;
		if (cfg.bad) begin
			stat_d = STAT_BAD_CFG;
		end else begin
			case (req.func)
				FUNC_INSERT: begin
					if (fresh_next_q < size_eff) begin
						op_d = OP_INS_FRESH;
					end else if (fifo_count_q != '0) begin
						op_d = OP_INS_FIFO;
					end else begin
						stat_d = STAT_FULL;
					end
				end
				FUNC_GET:    op_d = OP_GET;
				FUNC_REMOVE: op_d = OP_REM;
				default:     op_d = OP_FAIL;
			endcase
		end
	end

	assign fifo_re = accept && (op_d == OP_INS_FIFO);
	assign ent_re  = accept && ((op_d == OP_GET) || (op_d == OP_REM));

	// stage 1: take read data, write back, build result
	assign hit  = key_ok_s1 && ent_rdata[VALUE_BITS];
	assign slot = (op_s1 == OP_INS_FIFO) ? fifo_rdata : key_s1;

	always_comb begin
		ent_we    = 1'b0;
		ent_wdata = {1'b1, value_s1};
		rem_push  = 1'b0;
		res_key   = '0;
		res_value = '0;
		res_stat  = fail_stat_s1;
		case (op_s1) inside
			OP_INS_FRESH, OP_INS_FIFO: begin
				ent_we   = done;
				res_key  = slot;
				res_stat = STAT_OK;
			end
			OP_GET: begin
				if (hit) begin
					res_value = ent_rdata[VALUE_BITS-1:0];
					res_stat  = STAT_OK;
				end
			end
			OP_REM: begin
				if (hit) begin
					ent_we    = done;
					ent_wdata = {1'b0, ent_rdata[VALUE_BITS-1:0]};
					rem_push  = done && (fifo_count_q < CNT_W'(CAPACITY));
					res_stat  = STAT_OK;
				end
			end
			default: res_stat = fail_stat_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_next_q  <= '0;
			active_size_q <= CNT_W'(START_KEYS_RST);
			fifo_head_q   <= '0;
			fifo_tail_q   <= '0;
			fifo_count_q  <= '0;
			s1_valid_q    <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg.reinit) begin
				fresh_next_q  <= '0;
				active_size_q <= cfg.reload_size;
				fifo_head_q   <= '0;
				fifo_tail_q   <= '0;
				fifo_count_q  <= '0;
			end else begin
				if (accept && (op_d == OP_INS_FRESH)) begin
					fresh_next_q  <= fresh_next_q + 1'b1;
					active_size_q <= size_eff;
				end
				if (fifo_re) begin
					fifo_head_q  <= ring_next(fifo_head_q);
					fifo_count_q <= fifo_count_q - 1'b1;
				end
				if (rem_push) begin
					fifo_tail_q  <= ring_next(fifo_tail_q);
					fifo_count_q <= fifo_count_q + 1'b1;
				end
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (done) begin
				s1_valid_q <= 1'b0;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= op_d;
			key_s1       <= (op_d == OP_INS_FRESH) ? fresh_next_q[KEY_W-1:0] : req.key;
			value_s1     <= req.value;
			key_ok_s1    <= {1'b0, req.key} < fresh_next_q;
			fail_stat_s1 <= stat_d;
		end
		if (done) begin
			rsp_key_q    <= res_key;
			rsp_value_q  <= res_value;
			rsp_status_q <= res_stat;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_key   = rsp_key_q;
	assign rsp.out_value = rsp_value_q;
	assign rsp.status    = rsp_status_q;

	// valid mark and value of every key
	htab_ram #(
		.WIDTH(ENT_W),
		.DEPTH(CAPACITY)
	) u_ent_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(slot),
		.wdata(ent_wdata),
		.re   (ent_re),
		.raddr(req.key),
		.rdata(ent_rdata)
	);

	// ring of recycled keys
	htab_ram #(
		.WIDTH(KEY_W),
		.DEPTH(CAPACITY)
	) u_fifo_ram (
		.clk  (clk),
		.we   (rem_push),
		.waddr(fifo_tail_q),
		.wdata(key_s1),
		.re   (fifo_re),
		.raddr(fifo_head_q),
		.rdata(fifo_rdata)
	);

endmodule

`default_nettype wire

// ===== rtl/handle_table_allocator_unit.sv =====
// Top level of the handle table allocator: configuration registers and controller.
`default_nettype none

// Handle table with a FIFO free list. Each request transaction carries an
// operation (insert, get, remove), a key and a 64-bit value; each one
// yields exactly one response transaction with a key, a value and a status.
// Insert hands out never-used keys in ascending order first, then recycled
// keys in the order they were removed; when none is free the active size
// grows by the growth step if that stays within the size limit, else status
// is full. The cycle of acceptance issues the read of the entry memory (or of
// the recycle ring for an insert of a recycled key), and stage 1 then takes
// the read data, writes the entry back and loads the result register once
// that register is free or being taken. That read-then-write on the single
// entry memory keeps a new request from being accepted while one is still
// in stage 1; a finished result waiting in the output register does not
// block acceptance of the next request, but a second result cannot complete
// until the first is taken. The value and ring memories need no clearing
// after reset or a configuration write: a key is valid only if it lies below
// the count of keys handed out since initialization and its stored valid mark
// is set, so the block is ready as soon as reset is released. Write
// configuration only while idle; any write to a defined register reinitializes the table.
module handle_table_allocator_unit
	import htab_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	htab_req_if.sink                  req,
	htab_rsp_if.source                rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [REG_W-1:0]     cfg_wdata
);

	// clamp the size limit to the capacity
	function automatic logic [CNT_W-1:0] eff_max(input logic [REG_W-1:0] m);
		return (m > REG_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(m);
	endfunction

	logic [REG_W-1:0] start_keys_q;
	logic [REG_W-1:0] grow_by_q;
	logic [REG_W-1:0] size_limit_q;

	logic [REG_W-1:0] start_keys_d;
	logic [REG_W-1:0] grow_by_d;
	logic [REG_W-1:0] size_limit_d;
	logic             reinit;
	logic [CNT_W-1:0] eff_max_d;
	logic [CNT_W-1:0] eff_max_cur;
	cfg_t             cfg;

	// decode the register write
	always_comb begin
		start_keys_d = start_keys_q;
		grow_by_d    = grow_by_q;
		size_limit_d = size_limit_q;
		reinit       = 1'b0;
		if (cfg_we) begin
			unique case (cfg_idx)
				REG_START_KEYS: begin
					start_keys_d = cfg_wdata;
					reinit       = 1'b1;
				end
				REG_GROW_BY: begin
					grow_by_d = cfg_wdata;
					reinit    = 1'b1;
				end
				REG_SIZE_LIMIT: begin
					size_limit_d = cfg_wdata;
					reinit       = 1'b1;
				end
				default: reinit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_keys_q <= START_KEYS_RST;
			grow_by_q    <= GROW_BY_RST;
			size_limit_q <= SIZE_LIMIT_RST;
		end else begin
			start_keys_q <= start_keys_d;
			grow_by_q    <= grow_by_d;
			size_limit_q <= size_limit_d;
		end
	end

	assign eff_max_d   = eff_max(size_limit_d);
	assign eff_max_cur = eff_max(size_limit_q);

	// reload the active size from the new values; a bad setup starts empty
	assign cfg.reinit      = reinit;
	assign cfg.reload_size = (CNT_W'(start_keys_d) > eff_max_d) ? '0 : CNT_W'(start_keys_d);
	assign cfg.grow_by     = CNT_W'(grow_by_q);
	assign cfg.eff_max     = eff_max_cur;
	assign cfg.bad         = CNT_W'(start_keys_q) > eff_max_cur;

	htab_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.req   (req),
		.rsp   (rsp)
	);

`ifndef NO_ASSERTIONS
	// the read-then-write interlock: no request right after an accepted one
	a_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous operation in flight");

	// a failed operation carries neither key nor value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != STAT_OK) |-> (rsp.out_key == '0) &&
		(rsp.out_value == '0))
		else $error("failed operation returned a key or value");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_handle_table_allocator_unit.sv =====
// Self-checking testbench of the handle table allocator: directed and random table traffic.
`default_nettype none

module tb_handle_table_allocator_unit
	import htab_pkg::*;
	();

	timeunit 1ns;
	timeprecision 1ps;

	// Codes the package leaves out: the spare operation and the spare register slot.
	localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

	// Cycles with no transaction on either channel before the run is declared hung.
	// The longest correct pause is a sender gap plus a receiver stall, or a
	// settings change, so this is many times over.
	localparam int STALL_LIMIT = 600;

	typedef struct {
		logic [KEY_W-1:0]      key;
		logic [VALUE_BITS-1:0] value;
		logic [STAT_W-1:0]     status;
	} table_resp_t;

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [REG_W-1:0]     cfg_wdata;

	htab_req_if req_ch();
	htab_rsp_if rsp_ch();

	// Shadow copy of the table: settings, valid marks, stored values, recycle ring.
	logic [REG_W-1:0]      cfg_init, cfg_growth, cfg_max;
	bit                    tbl_valid [CAPACITY];
	logic [VALUE_BITS-1:0] tbl_value [CAPACITY];
	logic [KEY_W-1:0]      ring_keys [CAPACITY];
	logic [KEY_W-1:0]      ring_head, ring_tail;
	logic [CNT_W-1:0]      ring_count, act_size, next_fresh;
	logic [KEY_W-1:0]      live_keys[$];

	table_resp_t pending_rsp[$];
	table_resp_t head_rsp;

	int errors;
	int items_sent;
	int results_seen;
	int settings_used;
	int status_seen [4];
	int idle_cycles;
	int stall_left;
	bit quiet;

	handle_table_allocator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// A size limit above the capacity acts as the capacity.
	function automatic logic [CNT_W-1:0] limit_of_max();
		return (cfg_max > CAPACITY) ? CNT_W'(CAPACITY) : cfg_max;
	endfunction

	// Reinitialize the shadow table, as reset or a write to a defined register does.
	function automatic void reinit_table();
		foreach (tbl_valid[i])
			tbl_valid[i] = 1'b0;
		ring_head  = '0;
		ring_tail  = '0;
		ring_count = '0;
		act_size   = (cfg_init > limit_of_max()) ? '0 : cfg_init;
		next_fresh = '0;
		live_keys.delete();
	endfunction

	// Apply one operation to the shadow table and return the response it must give.
	function automatic table_resp_t predict_op(input logic [FUNC_W-1:0] f,
			input logic [KEY_W-1:0] k, input logic [VALUE_BITS-1:0] v);
		table_resp_t      r;
		logic [CNT_W:0]   grown;
		logic [KEY_W-1:0] slot;
		bit               got;
		r.key    = '0;
		r.value  = '0;
		r.status = STAT_OK;
		slot     = '0;
		got      = 1'b0;
		if (cfg_init > limit_of_max()) begin
			// bad settings: nothing changes
			r.status = STAT_BAD_CFG;
		end else if (f == FUNC_INSERT) begin
			// grow only when no fresh and no recycled key is left
			if (next_fresh >= act_size && ring_count == 0) begin
				grown = {1'b0, act_size} + {1'b0, cfg_growth};
				if (grown <= {1'b0, limit_of_max()})
					act_size = grown[CNT_W-1:0];
			end
			// fresh keys go out first, in ascending order
			if (next_fresh < act_size) begin
				slot = next_fresh[KEY_W-1:0];
				next_fresh++;
				got = 1'b1;
			end else if (ring_count != 0) begin
				slot = ring_keys[ring_head];
				ring_head++;
				ring_count--;
				got = 1'b1;
			end
			if (got) begin
				tbl_valid[slot] = 1'b1;
				tbl_value[slot] = v;
				r.key = slot;
				live_keys.push_back(slot);
			end else begin
				r.status = STAT_FULL;
			end
		end else if (f == FUNC_GET || f == FUNC_REMOVE) begin
			if ({1'b0, k} < act_size && tbl_valid[k]) begin
				if (f == FUNC_GET) begin
					r.value = tbl_value[k];
				end else begin
					tbl_valid[k] = 1'b0;
					if (ring_count < CAPACITY) begin
						ring_keys[ring_tail] = k;
						ring_tail++;
						ring_count++;
					end
					for (int i = 0; i < live_keys.size(); i++) begin
						if (live_keys[i] == k) begin
							live_keys.delete(i);
							break;
						end
					end
				end
			end else begin
				r.status = STAT_KEY_INVALID;
			end
		end else begin
			r.status = STAT_KEY_INVALID;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [VALUE_BITS-1:0] got,
			input logic [VALUE_BITS-1:0] want);
		$display("tb: mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
		errors++;
	endtask

	// Send one request transaction, after a random gap unless quiet; record what it must answer.
	task automatic send_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
			input logic [VALUE_BITS-1:0] v);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= f;
		req_ch.key   <= k;
		req_ch.value <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_rsp.push_back(predict_op(f, k, v));
		items_sent++;
	endtask

	// Drop valid and wait until every response is back, then let the pipeline settle.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Drive one register write; the caller lowers the write enable.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		case (idx)
			REG_START_KEYS: cfg_init   = d;
			REG_GROW_BY:    cfg_growth = d;
			REG_SIZE_LIMIT: cfg_max    = d;
			default:        return;
		endcase
		reinit_table();
	endtask

	task automatic config_table(input logic [REG_W-1:0] init, input logic [REG_W-1:0] growth,
			input logic [REG_W-1:0] max);
		wait_idle();
		write_reg(REG_START_KEYS, init);
		write_reg(REG_GROW_BY, growth);
		write_reg(REG_SIZE_LIMIT, max);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// A write to the spare index must leave the table as it is.
	task automatic poke_unused_reg(input logic [REG_W-1:0] d);
		wait_idle();
		write_reg(REG_UNUSED, d);
		cfg_we <= 1'b0;
	endtask

	// Reset settings: misses before any insert, the spare operation, value extremes,
	// a key beyond the active size, and a fresh key handed out before a recycled one.
	task automatic test_reset_defaults();
		send_op(FUNC_GET, 10'd0, '0);
		send_op(FUNC_UNUSED, 10'd0, '1);
		send_op(FUNC_INSERT, 10'h3FF, '1);
		send_op(FUNC_INSERT, 10'd0, '0);
		send_op(FUNC_GET, 10'd0, '0);
		send_op(FUNC_GET, 10'h3FF, '0);
		send_op(FUNC_REMOVE, 10'd0, '0);
		send_op(FUNC_GET, 10'd0, '0);
		send_op(FUNC_INSERT, 10'd0, 64'h0123_4567_89AB_CDEF);
	endtask

	// The growth step would pass the size limit, so inserts run full; a removed key is handed out again.
	task automatic test_growth_limit();
		config_table(11'd2, 11'd3, 11'd4);
		repeat (5)
			send_op(FUNC_INSERT, KEY_W'($urandom_range(0, 1023)), {$urandom(), $urandom()});
		send_op(FUNC_REMOVE, 10'd3, '0);
		send_op(FUNC_REMOVE, 10'd1, '0);
		send_op(FUNC_INSERT, 10'd0, '1);
		send_op(FUNC_INSERT, 10'd0, 64'h8000_0000_0000_0001);
		poke_unused_reg(11'h7FF);
		send_op(FUNC_GET, 10'd2, '0);
	endtask

	// Growth step of zero: once the initial keys are used, insert reports full.
	task automatic test_zero_growth();
		config_table(11'd1, 11'd0, 11'd1024);
		send_op(FUNC_INSERT, 10'd0, 64'h5555_5555_5555_5555);
		send_op(FUNC_INSERT, 10'd0, 64'hAAAA_AAAA_AAAA_AAAA);
	endtask

	// Starting key count above the effective limit, limit above capacity, all-zero sizes.
	task automatic test_bad_config();
		config_table(11'd20, 11'd5, 11'd10);
		send_op(FUNC_INSERT, 10'd0, '1);
		send_op(FUNC_GET, 10'd0, '0);
		config_table(11'd1025, 11'd0, 11'h7FF);
		send_op(FUNC_INSERT, 10'd0, '1);
		config_table(11'd1024, 11'd0, 11'h7FF);
		send_op(FUNC_INSERT, 10'd0, '1);
		config_table(11'd0, 11'd0, 11'd0);
		send_op(FUNC_INSERT, 10'd0, '1);
	endtask

	// Random traffic over several settings. Gets and removes mostly target live keys
	// so that the recycle ring and the growth path are exercised; the rest is noise.
	task automatic test_random_traffic();
		int                    ins_pct;
		int                    rest;
		int                    pick;
		logic [FUNC_W-1:0]     f;
		logic [KEY_W-1:0]      k;
		logic [VALUE_BITS-1:0] v;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: config_table(11'd1024, 11'd0, 11'd1024);
				1: config_table(11'd0, 11'd1024, 11'd1024);
				2: config_table(11'd16, 11'd16, 11'h7FF);
				default: config_table(REG_W'($urandom_range(0, 10)),
					REG_W'($urandom_range(0, 5)), REG_W'($urandom_range(0, 30)));
			endcase
			quiet   = (phase > 2) && ($urandom_range(0, 3) == 0);
			ins_pct = (phase % 2 == 1) ? 55 : 35;
			rest    = 95 - ins_pct;
			for (int n = 0; n < 100; n++) begin
				if (n == 50 && phase % 3 == 0)
					poke_unused_reg(REG_W'($urandom_range(0, 2047)));
				pick = $urandom_range(0, 99);
				if (pick < ins_pct)
					f = FUNC_INSERT;
				else if (pick < ins_pct + rest / 2)
					f = FUNC_GET;
				else if (pick < 95)
					f = FUNC_REMOVE;
				else
					f = FUNC_UNUSED;
				if (live_keys.size() != 0 && $urandom_range(0, 9) < 7)
					k = live_keys[$urandom_range(0, live_keys.size() - 1)];
				else
					k = KEY_W'($urandom_range(0, 1023));
				case ($urandom_range(0, 9))
					0:       v = '0;
					1:       v = '1;
					default: v = {$urandom(), $urandom()};
				endcase
				send_op(f, k, v);
			end
		end
		quiet = 1'b0;
	endtask

	// Response side: stall ready at random, longer now and then; no new stall starts in a quiet phase.
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare every response transaction with the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$display("tb: response with nothing outstanding at %0t", $time);
				errors++;
			end else begin
				head_rsp = pending_rsp.pop_front();
				results_seen++;
				status_seen[head_rsp.status]++;
				if (rsp_ch.out_key !== head_rsp.key)
					report_mismatch("out_key", VALUE_BITS'(rsp_ch.out_key),
						VALUE_BITS'(head_rsp.key));
				if (rsp_ch.out_value !== head_rsp.value)
					report_mismatch("out_value", rsp_ch.out_value, head_rsp.value);
				if (rsp_ch.status !== head_rsp.status)
					report_mismatch("status", VALUE_BITS'(rsp_ch.status),
						VALUE_BITS'(head_rsp.status));
			end
		end
	end

	// Watchdog: end the run if no transaction moves for too long.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: no transaction for %0d cycles at %0t", idle_cycles, $time);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		// Drive every input to a known value before the first edge.
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.func   = FUNC_INSERT;
		req_ch.key    = '0;
		req_ch.value  = '0;
		rsp_ch.ready  = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = REG_START_KEYS;
		cfg_wdata     = '0;
		errors        = 0;
		items_sent    = 0;
		results_seen  = 0;
		settings_used = 1;
		idle_cycles   = 0;
		stall_left    = 0;
		quiet         = 1'b0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		cfg_init   = START_KEYS_RST;
		cfg_growth = GROW_BY_RST;
		cfg_max    = SIZE_LIMIT_RST;
		reinit_table();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_growth_limit();
		test_zero_growth();
		test_bad_config();
		test_random_traffic();

		// Drain, then give a late or extra response time to show up.
		wait_idle();
		repeat (8) @(posedge clk);

		$display("tb: %0d requests under %0d table settings, %0d responses checked",
			items_sent, settings_used, results_seen);
		$display("tb: statuses seen: ok %0d, full %0d, key not valid %0d, bad settings %0d",
			status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_KEY_INVALID],
			status_seen[STAT_BAD_CFG]);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
